// File: src/lpg_pkg.sv
// Shared definitions for the line pixel generator: request kind codes,
// default coordinate width and the control flag group.
// No dependencies.
package lpg_pkg;

   localparam int COORD_BITS_DEFAULT = 12;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   typedef struct packed {
      logic major_is_y;
      logic minor_down;
      logic busy;
   } lpg_ctrl_type;

endpackage

// File: src/lpg_datapath.sv
// Next-state and pixel logic of the line pixel generator: line setup on load,
// one decision-term step on step. Depends on lpg_pkg.
module lpg_datapath #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         req_kind,
   input  logic [COORD_BITS-1:0]        req_start_x,
   input  logic [COORD_BITS-1:0]        req_start_y,
   input  logic [COORD_BITS-1:0]        req_end_x,
   input  logic [COORD_BITS-1:0]        req_end_y,
   input  logic [COORD_BITS-1:0]        cur_x,
   input  logic [COORD_BITS-1:0]        cur_y,
   input  logic signed [COORD_BITS+2:0] decision,
   input  logic [COORD_BITS+1:0]        inc_straight,
   input  logic signed [COORD_BITS+2:0] inc_diagonal,
   input  logic [COORD_BITS-1:0]        major_limit,
   input  lpg_pkg::lpg_ctrl_type        ctrl,
   output logic [COORD_BITS-1:0]        cur_x_nxt,
   output logic [COORD_BITS-1:0]        cur_y_nxt,
   output logic signed [COORD_BITS+2:0] decision_nxt,
   output logic [COORD_BITS+1:0]        inc_straight_nxt,
   output logic signed [COORD_BITS+2:0] inc_diagonal_nxt,
   output logic [COORD_BITS-1:0]        major_limit_nxt,
   output lpg_pkg::lpg_ctrl_type        ctrl_nxt,
   output logic [COORD_BITS-1:0]        pixel_x,
   output logic [COORD_BITS-1:0]        pixel_y,
   output logic                         pixel_valid,
   output logic                         last_pixel
);

   logic [COORD_BITS-1:0]        dx, dy, maj_d, min_d;
   logic                         major_y, swap;
   logic [COORD_BITS-1:0]        major, minor, major_step, minor_step;
   logic                         move_minor;
   logic signed [COORD_BITS+2:0] dec_sum;

   always_comb begin
      dx = (req_end_x > req_start_x) ? req_end_x - req_start_x : req_start_x - req_end_x;
      dy = (req_end_y > req_start_y) ? req_end_y - req_start_y : req_start_y - req_end_y;
      major_y = !(dy < dx);
      maj_d = major_y ? dy : dx;
      min_d = major_y ? dx : dy;
      swap  = major_y ? (req_start_y > req_end_y) : (req_start_x > req_end_x);

      move_minor = !decision[COORD_BITS+2];
      major = ctrl.major_is_y ? cur_y : cur_x;
      minor = ctrl.major_is_y ? cur_x : cur_y;
      major_step = major + COORD_BITS'(1);
      if (!move_minor) begin
         minor_step = minor;
      end else if (ctrl.minor_down) begin
         minor_step = minor - COORD_BITS'(1);
      end else begin
         minor_step = minor + COORD_BITS'(1);
      end
      dec_sum = decision + (move_minor ? inc_diagonal : $signed({1'b0, inc_straight}));

      cur_x_nxt        = cur_x;
      cur_y_nxt        = cur_y;
      decision_nxt     = decision;
      inc_straight_nxt = inc_straight;
      inc_diagonal_nxt = inc_diagonal;
      major_limit_nxt  = major_limit;
      ctrl_nxt         = ctrl;
      pixel_x          = '0;
      pixel_y          = '0;
      pixel_valid      = 1'b0;
      last_pixel       = 1'b0;

      if (req_kind == lpg_pkg::KIND_LOAD) begin
         cur_x_nxt = swap ? req_end_x : req_start_x;
         cur_y_nxt = swap ? req_end_y : req_start_y;
         if (swap) begin
            major_limit_nxt     = major_y ? req_start_y : req_start_x;
            ctrl_nxt.minor_down = major_y ? (req_start_x < req_end_x)
                                          : (req_start_y < req_end_y);
         end else begin
            major_limit_nxt     = major_y ? req_end_y : req_end_x;
            ctrl_nxt.minor_down = major_y ? (req_end_x < req_start_x)
                                          : (req_end_y < req_start_y);
         end
         decision_nxt        = $signed({2'b00, min_d, 1'b0}) - $signed({3'b000, maj_d});
         inc_straight_nxt    = {1'b0, min_d, 1'b0};
         inc_diagonal_nxt    = $signed({2'b00, min_d, 1'b0}) - $signed({2'b00, maj_d, 1'b0});
         ctrl_nxt.major_is_y = major_y;
         ctrl_nxt.busy       = (maj_d != '0);
         pixel_x             = cur_x_nxt;
         pixel_y             = cur_y_nxt;
         pixel_valid         = 1'b1;
         last_pixel          = (maj_d == '0);
      end else if (ctrl.busy) begin
         cur_x_nxt     = ctrl.major_is_y ? minor_step : major_step;
         cur_y_nxt     = ctrl.major_is_y ? major_step : minor_step;
         decision_nxt  = dec_sum;
         ctrl_nxt.busy = (major_step != major_limit);
         pixel_x       = cur_x_nxt;
         pixel_y       = cur_y_nxt;
         pixel_valid   = 1'b1;
         last_pixel    = (major_step == major_limit);
      end
   end

endmodule

// File: src/line_pixel_generator_core.sv
// Line pixel generator: integer line rasterizer, at most one pixel per request.
// Top level with state and result registers; depends on lpg_pkg and lpg_datapath.
//
// Usage: a request with req_kind = load carries two endpoints; the block picks
// the major axis (ties go to Y), starts at the endpoint with the smaller major
// coordinate and returns that pixel. Each request with req_kind = step advances
// the major coordinate by one and returns the next pixel; rsp_last_pixel marks
// the line's final pixel. A step with no line in progress returns
// rsp_pixel_valid = 0 with zero coordinates. A load drops any line in progress.
// Every request gives exactly one response, in the cycle after acceptance (the
// result register). Throughput is one request per cycle while rsp_ready is high:
// the line state and the result register are both updated at the accept edge, so
// a step may follow a load or a step in the next cycle. If the receiver stalls,
// the response holds in the result register and req_ready falls until it is
// taken; req_ready is high whenever the result register is empty or being emptied.
// Synchronous reset empties the result register and leaves the block idle.
module line_pixel_generator_core #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_pixel_valid,
   output logic                  rsp_last_pixel
);

   logic                         accept;
   logic [COORD_BITS-1:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS+2:0] decision_ff, decision_in;
   logic [COORD_BITS+1:0]        inc_straight_ff, inc_straight_in;
   logic signed [COORD_BITS+2:0] inc_diagonal_ff, inc_diagonal_in;
   logic [COORD_BITS-1:0]        major_limit_ff, major_limit_in;
   lpg_pkg::lpg_ctrl_type        ctrl_ff, ctrl_nxt, ctrl_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]        pix_x, pix_y, rsp_pixel_x_ff, rsp_pixel_y_ff;
   logic                         pix_valid, pix_last, rsp_pixel_valid_ff, rsp_last_pixel_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   lpg_datapath #(
      .COORD_BITS(COORD_BITS)
   ) u_datapath (
      .req_kind         (req_kind),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .cur_x            (cur_x_ff),
      .cur_y            (cur_y_ff),
      .decision         (decision_ff),
      .inc_straight     (inc_straight_ff),
      .inc_diagonal     (inc_diagonal_ff),
      .major_limit      (major_limit_ff),
      .ctrl             (ctrl_ff),
      .cur_x_nxt        (cur_x_in),
      .cur_y_nxt        (cur_y_in),
      .decision_nxt     (decision_in),
      .inc_straight_nxt (inc_straight_in),
      .inc_diagonal_nxt (inc_diagonal_in),
      .major_limit_nxt  (major_limit_in),
      .ctrl_nxt         (ctrl_nxt),
      .pixel_x          (pix_x),
      .pixel_y          (pix_y),
      .pixel_valid      (pix_valid),
      .last_pixel       (pix_last)
   );

   always_comb begin
      ctrl_in      = accept ? ctrl_nxt : ctrl_ff;
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctrl_ff      <= ctrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_x_ff           <= cur_x_in;
         cur_y_ff           <= cur_y_in;
         decision_ff        <= decision_in;
         inc_straight_ff    <= inc_straight_in;
         inc_diagonal_ff    <= inc_diagonal_in;
         major_limit_ff     <= major_limit_in;
         rsp_pixel_x_ff     <= pix_x;
         rsp_pixel_y_ff     <= pix_y;
         rsp_pixel_valid_ff <= pix_valid;
         rsp_last_pixel_ff  <= pix_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_pixel_x_ff;
   assign rsp_pixel_y     = rsp_pixel_y_ff;
   assign rsp_pixel_valid = rsp_pixel_valid_ff;
   assign rsp_last_pixel  = rsp_last_pixel_ff;

   a_last_matches_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (!rsp_pixel_valid || (rsp_last_pixel == !ctrl_ff.busy)))
      else $error("last pixel flag disagrees with line state");

   a_idle_step_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == lpg_pkg::KIND_STEP && !ctrl_ff.busy)
         |=> (!ctrl_ff.busy && !rsp_pixel_valid && !rsp_last_pixel))
      else $error("idle step changed state or produced a pixel");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request stalled with empty result register");

   a_point_line_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == lpg_pkg::KIND_LOAD && req_start_x == req_end_x
         && req_start_y == req_end_y) |=> (!ctrl_ff.busy && rsp_last_pixel))
      else $error("single-pixel line left the block busy");

endmodule
